// File: hw/rtl/priority_wait_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority wait queue
// Concurrent checks clocked on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_WAIT_QUEUE_TOP_MACROS_SVH
`define PRIORITY_WAIT_QUEUE_TOP_MACROS_SVH

// check outside reset
`define PWQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define PWQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pwq_pkg.sv
// ----------------------------------------------------------------------------
// Priority wait queue package
// Sizes, action codes, entry and memory request types, pointer helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_WAIT = 2'd0;
  localparam logic [1:0] ACT_ONE  = 2'd1;
  localparam logic [1:0] ACT_ALL  = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [7:0] thread;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
  } mem_req_t;

  function automatic addr_t ptr_inc(input addr_t p);
    return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : ADDR_W'(p + 1'b1);
  endfunction

  function automatic addr_t ptr_dec(input addr_t p);
    return (p == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : ADDR_W'(p - 1'b1);
  endfunction

endpackage

// File: hw/rtl/pwq_ram.sv
// ----------------------------------------------------------------------------
// Priority wait queue entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwq_ram (
  input  logic              clk,
  input  pwq_pkg::mem_req_t req,
  output pwq_pkg::entry_t   rd_data
);
  import pwq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: hw/rtl/priority_wait_queue_top.sv
// ----------------------------------------------------------------------------
// Priority wait queue
// Thread ids ordered by descending priority, FIFO among equal priorities.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes action, thread_id, thread_priority.
// Output channel (out_valid/out_ready) gives woken_thread, woken_valid,
// overflow and last; last marks the final result of each input item.
// Entries sit in a circular buffer in one memory, kept sorted from head.
// Enqueue walks back from the tail, moving lower-priority entries up one
// slot: each entry examined is read in ST_INS_RD, then compared and moved
// in ST_INS_CMP, and the new entry is written where the walk stops.
// A refused enqueue, an empty wake or an unused action gives its result
// from ST_RESP; wake one reads the head entry and gives it from ST_POP_OUT.
// Wake all reads the head entry, then gives one result per cycle while the
// receiver takes them. in_ready returns with the final result, so the next
// item can be accepted while that result is presented.
// One item is processed at a time; in_ready is high whenever no item is in
// progress, even while a result waits in the output register.
// A stalled receiver holds the output register and the step that loads it.
// Reset empties the queue and drops any pending result; memory contents
// are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_wait_queue_top_macros.svh"

module priority_wait_queue_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] thread_id,
  input  logic [7:0] thread_priority,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] woken_thread,
  output logic       woken_valid,
  output logic       overflow,
  output logic       last
);
  import pwq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_INS_RD  = 5'b00010,
    ST_INS_CMP = 5'b00100,
    ST_POP_OUT = 5'b01000,
    ST_RESP    = 5'b10000
  } state_t;

  localparam cnt_t FULL_CNT = CNT_W'(QUEUE_DEPTH);

  state_t     state, state_next;
  addr_t      head, head_next;
  cnt_t       count, count_next;
  addr_t      pos, pos_next;
  addr_t      remain, remain_next;
  logic       all_mode, all_mode_next;
  logic       res_ovf, res_ovf_next;
  logic [7:0] cur_thread, cur_thread_next;
  logic [7:0] cur_prio, cur_prio_next;

  logic       out_valid_next;
  logic [7:0] woken_thread_next;
  logic       woken_valid_next, overflow_next, last_next;

  mem_req_t    req;
  entry_t      rd_data;
  logic        load_ok;
  logic        in_fire;
  logic [ADDR_W:0] tail_sum;
  addr_t       tail;

  pwq_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = !out_valid || out_ready;

  assign tail_sum = (ADDR_W + 1)'(head) + (ADDR_W + 1)'(count);
  assign tail     = (tail_sum >= (ADDR_W + 1)'(QUEUE_DEPTH))
                  ? ADDR_W'(tail_sum - (ADDR_W + 1)'(QUEUE_DEPTH))
                  : ADDR_W'(tail_sum);

  always_comb begin
    state_next        = state;
    head_next         = head;
    count_next        = count;
    pos_next          = pos;
    remain_next       = remain;
    all_mode_next     = all_mode;
    res_ovf_next      = res_ovf;
    cur_thread_next   = cur_thread;
    cur_prio_next     = cur_prio;
    out_valid_next    = out_valid && !out_ready;
    woken_thread_next = woken_thread;
    woken_valid_next  = woken_valid;
    overflow_next     = overflow;
    last_next         = last;
    req               = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cur_thread_next = thread_id;
          cur_prio_next   = thread_priority;
          all_mode_next   = (action == ACT_ALL);
          res_ovf_next    = 1'b0;
          priority if (action == ACT_WAIT) begin
            if (count == FULL_CNT) begin
              res_ovf_next = 1'b1;
              state_next   = ST_RESP;
            end else begin
              pos_next    = tail;
              remain_next = count[ADDR_W-1:0];
              state_next  = ST_INS_RD;
            end
          end else if (action == ACT_ONE || action == ACT_ALL) begin
            if (count == '0) begin
              state_next = ST_RESP;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = head;
              state_next  = ST_POP_OUT;
            end
          end else begin
            state_next = ST_RESP;
          end
        end
      end

      ST_INS_RD: begin
        if (remain == '0) begin
          req.wr_en   = 1'b1;
          req.wr_addr = pos;
          req.wr_data = '{thread: cur_thread, prio: cur_prio};
          count_next  = CNT_W'(count + 1'b1);
          state_next  = ST_RESP;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = ptr_dec(pos);
          state_next  = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = pos;
        if (rd_data.prio >= cur_prio) begin
          req.wr_data = '{thread: cur_thread, prio: cur_prio};
          count_next  = CNT_W'(count + 1'b1);
          state_next  = ST_RESP;
        end else begin
          req.wr_data = rd_data;
          pos_next    = ptr_dec(pos);
          remain_next = ADDR_W'(remain - 1'b1);
          state_next  = ST_INS_RD;
        end
      end

      ST_POP_OUT: begin
        if (load_ok) begin
          out_valid_next    = 1'b1;
          woken_thread_next = rd_data.thread;
          woken_valid_next  = 1'b1;
          overflow_next     = 1'b0;
          last_next         = !all_mode || (count == CNT_W'(1));
          head_next         = ptr_inc(head);
          count_next        = CNT_W'(count - 1'b1);
          if (all_mode && count != CNT_W'(1)) begin
            req.rd_en   = 1'b1;
            req.rd_addr = ptr_inc(head);
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        if (load_ok) begin
          out_valid_next    = 1'b1;
          woken_thread_next = '0;
          woken_valid_next  = 1'b0;
          overflow_next     = res_ovf;
          last_next         = 1'b1;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos          <= pos_next;
    remain       <= remain_next;
    all_mode     <= all_mode_next;
    res_ovf      <= res_ovf_next;
    cur_thread   <= cur_thread_next;
    cur_prio     <= cur_prio_next;
    woken_thread <= woken_thread_next;
    woken_valid  <= woken_valid_next;
    overflow     <= overflow_next;
    last         <= last_next;
  end

  `PWQ_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0) && !out_valid, "reset left queue busy")
  `PWQ_ASSERT(a_count_bound, count <= FULL_CNT, "entry count beyond depth")
  `PWQ_ASSERT(a_pop_nonempty, (state == ST_POP_OUT) |-> (count != '0), "pop on empty queue")
  `PWQ_ASSERT(a_full_refuse, (in_fire && action == ACT_WAIT && count == FULL_CNT) |=> (state == ST_RESP) && res_ovf && (count == FULL_CNT), "full enqueue not refused")

endmodule

// File: dv/priority_wait_queue_tb.sv
// ----------------------------------------------------------------------------
// Priority wait queue testbench
// Drives waiter enqueues, wake-one, wake-all and unused actions through the
// valid/ready input channel, tracks a shadow copy of the sorted waiter list,
// and checks every result field against the predicted wake sequence while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pwq_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 8;

  typedef struct packed {
    logic [7:0] tid;
    logic       has_tid;
    logic       ovf;
    logic       is_last;
  } wake_t;

  logic       clk             = 1'b0;
  logic       rst             = 1'b1;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [1:0] action          = ACT_WAIT;
  logic [7:0] thread_id       = 8'd0;
  logic [7:0] thread_priority = 8'd0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [7:0] woken_thread;
  logic       woken_valid;
  logic       overflow;
  logic       last;

  entry_t shadow_waiters[$];
  wake_t  pending_wakes[$];

  int mismatches    = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  bit gaps_enabled  = 1'b1;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int ready_mode    = 0;
  int mode_left     = 0;

  priority_wait_queue_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .thread_id      (thread_id),
    .thread_priority(thread_priority),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .woken_thread   (woken_thread),
    .woken_valid    (woken_valid),
    .overflow       (overflow),
    .last           (last)
  );

  always #5 clk = ~clk;

  function automatic void predict_wakes(input logic [1:0] act, input logic [7:0] tid,
                                        input logic [7:0] pr);
    int     pos;
    entry_t head;
    case (act)
      ACT_WAIT: begin
        if (shadow_waiters.size() >= QUEUE_DEPTH) begin
          pending_wakes.push_back('{8'd0, 1'b0, 1'b1, 1'b1});
        end else begin
          pos = 0;
          while (pos < shadow_waiters.size() && shadow_waiters[pos].prio >= pr) pos++;
          shadow_waiters.insert(pos, '{thread: tid, prio: pr});
          pending_wakes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
        end
      end
      ACT_ONE: begin
        if (shadow_waiters.size() == 0) begin
          pending_wakes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
        end else begin
          head = shadow_waiters.pop_front();
          pending_wakes.push_back('{head.thread, 1'b1, 1'b0, 1'b1});
        end
      end
      ACT_ALL: begin
        if (shadow_waiters.size() == 0) begin
          pending_wakes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
        end else begin
          while (shadow_waiters.size() > 0) begin
            head = shadow_waiters.pop_front();
            pending_wakes.push_back('{head.thread, 1'b1, 1'b0,
                                      shadow_waiters.size() == 0});
          end
        end
      end
      default: pending_wakes.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
    endcase
  endfunction

  task automatic send_action(input logic [1:0] act, input logic [7:0] tid,
                             input logic [7:0] pr);
    int gap;
    gap = 0;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 7);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    thread_id       <= tid;
    thread_priority <= pr;
    do @(posedge clk); while (!in_ready);
    predict_wakes(act, tid, pr);
  endtask

  task automatic await_all_wakes();
    if (in_valid) in_valid <= 1'b0;
    while (pending_wakes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    int k;
    gaps_enabled = 1'b0;
    send_action(ACT_ONE, 8'hA5, 8'h5A);
    send_action(ACT_ALL, 8'h5A, 8'hA5);
    send_action(ACT_UNUSED, 8'hFF, 8'hFF);
    send_action(ACT_WAIT, 8'd0, 8'd0);
    send_action(ACT_WAIT, 8'd255, 8'd255);
    send_action(ACT_WAIT, 8'd7, 8'd128);
    send_action(ACT_WAIT, 8'd200, 8'd255);
    send_action(ACT_ONE, 8'd0, 8'd0);
    for (k = 0; k < QUEUE_DEPTH - 3; k++)
      send_action(ACT_WAIT, 8'(8'h80 | k), 8'(k % 3 == 0 ? 255 : k * 19));
    send_action(ACT_WAIT, 8'h3C, 8'hC3);
    send_action(ACT_ALL, 8'd0, 8'd0);
    await_all_wakes();
  endtask

  task automatic test_stalled_receiver();
    int k;
    logic [1:0] act;
    gaps_enabled = 1'b0;
    hold_requests++;
    for (k = 0; k < 40; k++) begin
      act = ($urandom_range(0, 9) < 7) ? ACT_WAIT : ACT_ONE;
      if (k == 25) act = ACT_ALL;
      send_action(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    await_all_wakes();
  endtask

  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         seg_left;
    int         phase;
    int         pick;
    logic [1:0] act;
    logic [7:0] pr;
    sent = 0;
    seg_left = 0;
    phase = 0;
    while (sent < n_items) begin
      if (seg_left == 0) begin
        if (sent == 0 || $urandom_range(0, 3) == 0) await_all_wakes();
        seg_left = $urandom_range(15, 40);
        phase = $urandom_range(0, 2);
        gaps_enabled = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      case (phase)
        0:       act = pick < 80 ? ACT_WAIT : pick < 92 ? ACT_ONE : pick < 98 ? ACT_ALL
                                                                            : ACT_UNUSED;
        1:       act = pick < 30 ? ACT_WAIT : pick < 85 ? ACT_ONE : pick < 96 ? ACT_ALL
                                                                            : ACT_UNUSED;
        default: act = pick < 55 ? ACT_WAIT : pick < 85 ? ACT_ONE : pick < 96 ? ACT_ALL
                                                                            : ACT_UNUSED;
      endcase
      case ($urandom_range(0, 3))
        0:       pr = 8'($urandom_range(0, 3));
        1:       pr = 8'($urandom_range(252, 255));
        default: pr = 8'($urandom_range(0, 255));
      endcase
      send_action(act, 8'($urandom_range(0, 255)), pr);
      sent++;
      seg_left--;
    end
    await_all_wakes();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(32, 256);
        ready_mode = $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    wake_t got;
    wake_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{woken_thread, woken_valid, overflow, last};
      if (pending_wakes.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result thread=%0d valid=%0b ovf=%0b last=%0b",
                   $realtime, got.tid, got.has_tid, got.ovf, got.is_last);
        mismatches++;
      end else begin
        want = pending_wakes.pop_front();
        if (got.tid !== want.tid || got.has_tid !== want.has_tid ||
            got.ovf !== want.ovf || got.is_last !== want.is_last) begin
          if (mismatches < 10)
            $display("%0t: mismatch thread %0d/%0d valid %0b/%0b ovf %0b/%0b last %0b/%0b",
                     $realtime, want.tid, got.tid, want.has_tid, got.has_tid,
                     want.ovf, got.ovf, want.is_last, got.is_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_stalled_receiver();
    test_random_traffic(350);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_wakes.size() != 0) begin
      $display("%0d expected results never arrived", pending_wakes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pwq_pkg.sv
hw/rtl/pwq_ram.sv
hw/rtl/priority_wait_queue_top.sv
dv/priority_wait_queue_tb.sv
